// ===== hdl/sdcft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcft_pkg: shared types and constants for the spring-damped frame tracker
// Operation codes, register map, fixed-point helpers, time-to-frame constants.
// ----------------------------------------------------------------------------
package sdcft_pkg;

	localparam int unsigned FRAME_W   = 6;
	localparam int unsigned TFRAME_W  = 8;
	localparam int unsigned HOUR_W    = 5;
	localparam int unsigned MIN_W     = 6;
	localparam int unsigned SEC_W     = 6;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned COEF_W    = 16;
	localparam int unsigned Q_W       = 32;
	localparam int unsigned FRAC_W    = 16;

	// seconds of day, fields up to their full width: 31*3600 + 63*60 + 63 < 2^17
	localparam int unsigned SECS_W = 17;

	localparam logic [FRAME_W-1:0] FRAME_MAX = 6'd63;

	// floor(secs / 1350) = (secs * DAY_RECIP) >> DAY_SHIFT, exact over 17 bits
	localparam int unsigned DAY_RECIP   = 198842;
	localparam int unsigned DAY_RECIP_W = 18;
	localparam int unsigned DAY_SHIFT   = 28;
	localparam int unsigned DAY_PROD_W  = SECS_W + DAY_RECIP_W;

	// floor(secs * 4 / 75) = (secs * MIN_RECIP) >> MIN_SHIFT, exact over 17 bits
	localparam int unsigned MIN_RECIP   = 3579140;
	localparam int unsigned MIN_RECIP_W = 22;
	localparam int unsigned MIN_SHIFT   = 26;
	localparam int unsigned MIN_PROD_W  = SECS_W + MIN_RECIP_W;

	localparam logic [COEF_W-1:0] STIFFNESS_RST = 16'd1966;
	localparam logic [COEF_W-1:0] DAMPING_RST   = 16'd52429;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_SET_FRAME = 2'd1,
		OP_SET_TIME  = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DAY_MODE  = 2'd2;

	// saturate a 34-bit signed value to signed Q15.16
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [Q_W+1:0] v);
		logic signed [Q_W-1:0] r;
		if ((v[Q_W+1] == v[Q_W]) && (v[Q_W] == v[Q_W-1])) begin
			r = v[Q_W-1:0];
		end else if (v[Q_W+1]) begin
			r = {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(Q_W-1){1'b1}}};
		end
		return r;
	endfunction

	// integer part of a Q15.16 position, clamped to the frame range
	function automatic logic [FRAME_W-1:0] shown_frame(input logic signed [Q_W-1:0] p);
		logic [FRAME_W-1:0] r;
		if (p[Q_W-1]) begin
			r = '0;
		end else if (|p[Q_W-2:FRAC_W+FRAME_W]) begin
			r = FRAME_MAX;
		end else begin
			r = p[FRAC_W +: FRAME_W];
		end
		return r;
	endfunction

endpackage

// ===== hdl/spring_damped_clock_frame_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damped_clock_frame_tracker: spring/damper display frame follower
// Moves a Q15.16 position toward a target frame; reports the shown frame.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  request  | in_valid / in_ready  | op, target_frame, time_valid, hour,
//           |                      | minute, second
//  result   | out_valid/out_ready  | display_frame
//  config   | cfg_wr_en            | cfg_index, cfg_data (write only)
//
//  One request per cycle sustained while the result side is not stalled; a
//  taken request passes the input register, then the result register,
//  whose load raises out_valid.
//  The rate is set by the state loop: position and velocity are updated
//  together from a 32x17 multiply pair followed by two saturating adds.
//  Seconds of day are summed ahead of the input register; the time-to-frame
//  reciprocal multiply sits behind it.
//  A stalled result holds the result register; the input register still
//  drains into it once taken, so in_ready only drops when both are full.
//  Reset clears position, velocity, target and loads the default
//  coefficients; no clearing pass.
// ----------------------------------------------------------------------------
module spring_damped_clock_frame_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [sdcft_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sdcft_pkg::CFG_DAT_W-1:0]      cfg_data,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  sdcft_pkg::op_t                       op,
	input  logic [sdcft_pkg::TFRAME_W-1:0]       target_frame,
	input  logic                                 time_valid,
	input  logic [sdcft_pkg::HOUR_W-1:0]         hour,
	input  logic [sdcft_pkg::MIN_W-1:0]          minute,
	input  logic [sdcft_pkg::SEC_W-1:0]          second,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [sdcft_pkg::FRAME_W-1:0]        display_frame
);
	import sdcft_pkg::*;

	// ---------------- configuration registers ----------------
	logic [COEF_W-1:0] stiffness_q;
	logic [COEF_W-1:0] damping_q;
	logic              day_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFFNESS_RST;
			damping_q   <= DAMPING_RST;
			day_mode_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_STIFFNESS: stiffness_q <= cfg_data;
				REG_DAMPING:   damping_q   <= cfg_data;
				REG_DAY_MODE:  day_mode_q  <= cfg_data[0];
				default:       ; // unmapped index, ignored
			endcase
		end
	end

	// ---------------- request side: pre-compute before input register ----------------
	logic [SECS_W-1:0]  secs_in;
	logic [FRAME_W-1:0] frame_clamp_in;

	// constant multiplies reduce to shift-add trees
	assign secs_in = SECS_W'(hour) * SECS_W'(3600) + SECS_W'(minute) * SECS_W'(60)
		+ SECS_W'(second);
	assign frame_clamp_in = (target_frame > TFRAME_W'(FRAME_MAX)) ? FRAME_MAX
		: target_frame[FRAME_W-1:0];

	// ---------------- input register ----------------
	logic               valid_s1;
	op_t                op_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic               tvalid_s1;
	logic [SECS_W-1:0]  secs_s1;
	logic               adv_s1;
	logic               out_valid_q;
	logic [FRAME_W-1:0] display_frame_q;

	// stage 1 moves into the result register when that one is empty or being taken
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1     <= op;
			frame_s1  <= frame_clamp_in;
			tvalid_s1 <= time_valid;
			secs_s1   <= secs_in;
		end
	end

	// ---------------- model state ----------------
	logic signed [Q_W-1:0] pos_q;
	logic signed [Q_W-1:0] vel_q;
	logic [FRAME_W-1:0]    target_q;

	// ---------------- time of day to frame ----------------
	logic [DAY_PROD_W-1:0] day_prod;
	logic [MIN_PROD_W-1:0] min_prod;
	logic [FRAME_W-1:0]    time_quot;
	logic [FRAME_W-1:0]    time_frame;

	assign day_prod  = DAY_PROD_W'(secs_s1) * DAY_PROD_W'(DAY_RECIP);
	assign min_prod  = MIN_PROD_W'(secs_s1) * MIN_PROD_W'(MIN_RECIP);
	// only the low six quotient bits matter after the modulo-64 wrap
	assign time_quot = day_mode_q ? min_prod[MIN_SHIFT +: FRAME_W]
		: day_prod[DAY_SHIFT +: FRAME_W];
	// +32 mod 64 is a flip of the top bit
	assign time_frame = tvalid_s1 ? {~time_quot[FRAME_W-1], time_quot[FRAME_W-2:0]}
		: '0;

	// ---------------- spring / damper update ----------------
	logic signed [Q_W:0]          x_wide;
	logic signed [Q_W-1:0]        x_sat;
	logic signed [Q_W+COEF_W:0]   damp_prod;
	logic signed [Q_W+COEF_W:0]   spring_prod;
	logic signed [Q_W+1:0]        vel_sum;
	logic signed [Q_W-1:0]        vel_next;
	logic signed [Q_W+1:0]        pos_sum;
	logic signed [Q_W-1:0]        pos_next;

	assign x_wide = {pos_q[Q_W-1], pos_q}
		- {{(Q_W+1-FRAME_W-FRAC_W){1'b0}}, target_q, {FRAC_W{1'b0}}};
	assign x_sat  = sat_q((Q_W+2)'(x_wide));

	assign damp_prod   = vel_q * $signed({1'b0, damping_q});
	assign spring_prod = x_sat * $signed({1'b0, stiffness_q});

	// dropping the low 16 bits of a signed product is the floor shift
	assign vel_sum  = (Q_W+2)'($signed(damp_prod[Q_W+COEF_W:FRAC_W]))
		- (Q_W+2)'($signed(spring_prod[Q_W+COEF_W:FRAC_W]));
	assign vel_next = sat_q(vel_sum);
	assign pos_sum  = (Q_W+2)'(pos_q) + (Q_W+2)'(vel_next);
	assign pos_next = sat_q(pos_sum);

	// shown frame follows the position after this request
	logic [FRAME_W-1:0] frame_res;
	assign frame_res = (op_s1 == OP_TICK) ? shown_frame(pos_next) : shown_frame(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			vel_q    <= '0;
			target_q <= '0;
		end else if (adv_s1) begin
			case (op_s1)
				OP_TICK: begin
					pos_q <= pos_next;
					vel_q <= vel_next;
				end
				OP_SET_FRAME: target_q <= frame_s1;
				OP_SET_TIME:  target_q <= time_frame;
				default:      ; // unused code leaves the state alone
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			display_frame_q <= frame_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign display_frame = display_frame_q;

	// ---------------- assertions ----------------
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("stage 1 advanced but result register is empty");

	a_full_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("request taken while both stages are full and stalled");

	a_set_keeps_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 != OP_TICK) |=> ($stable(pos_q) && $stable(vel_q)))
		else $error("set operation changed position or velocity");

	a_tick_keeps_target: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 == OP_TICK) |=> $stable(target_q))
		else $error("tick changed the target");

	a_idle_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(pos_q) && $stable(vel_q) && $stable(target_q)))
		else $error("state changed with no request advancing");

endmodule

// ===== tb/spring_damped_clock_frame_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damped_clock_frame_tracker_tb: self-checking bench for the frame tracker
// A short table of directed requests, then random request streams under several
// coefficient and day-mode settings. A spring/damper model inside the bench
// predicts every shown frame; results are compared in order of arrival.
// ----------------------------------------------------------------------------
module spring_damped_clock_frame_tracker_tb;
	import sdcft_pkg::*;

	// op code with no meaning in the block, and a register index past the map
	localparam logic [1:0]           OP_SPARE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int NO_PIN          = -1;    // row result comes from the model
	localparam int N_SCRIPT        = 20;
	localparam int N_SETTINGS      = 7;
	localparam int RAND_ITEMS      = 145;   // random requests per setting
	localparam int RANDOM_SETTING  = 5;     // coefficients drawn at run time
	localparam int SQUEEZE_SETTING = 1;     // setting that sees the long hold-off
	localparam int SQUEEZE_CYCLES  = 120;
	localparam int SETTLE_CYCLES   = 4;     // two-stage latency plus margin
	localparam int QUIET_LIMIT     = 2000;  // cycles with no traffic before giving up
	localparam int MAX_REPORTS     = 40;

	localparam longint Q_HI = 64'sd2147483647;
	localparam longint Q_LO = -Q_HI - 1;

	typedef struct packed {
		logic [1:0]          code;
		logic [TFRAME_W-1:0] frame;
		logic                tv;
		logic [HOUR_W-1:0]   h;
		logic [MIN_W-1:0]    m;
		logic [SEC_W-1:0]    s;
		int                  pinned;   // typed-in result, or NO_PIN
	} request_t;

	typedef struct packed {
		logic [COEF_W-1:0] k;          // stiffness
		logic [COEF_W-1:0] c;          // damping
		logic              mode;       // 1: 20-minute day
		int                gap_pct;    // chance of a sender gap before a request
		int                stall_pct;  // chance of a receiver stall per cycle
	} setting_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	op_t                  op;
	logic [TFRAME_W-1:0]  target_frame;
	logic                 time_valid;
	logic [HOUR_W-1:0]    hour;
	logic [MIN_W-1:0]     minute;
	logic [SEC_W-1:0]     second;
	logic                 out_valid;
	logic                 out_ready;
	logic [FRAME_W-1:0]   display_frame;

	spring_damped_clock_frame_tracker uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.target_frame  (target_frame),
		.time_valid    (time_valid),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.display_frame (display_frame)
	);

	// Directed requests. Right after reset position, velocity and target are all
	// zero, so until the first real retarget every shown frame is plainly 0.
	request_t script [N_SCRIPT] = '{
		'{OP_TICK,      8'd0,   1'b0, 5'd0,  6'd0,  6'd0,  0},      // tick at rest
		'{OP_SPARE,     8'hFF,  1'b1, 5'd31, 6'd63, 6'd63, 0},      // unused op
		'{OP_SET_FRAME, 8'd255, 1'b0, 5'd0,  6'd0,  6'd0,  0},      // clamps to 63
		'{OP_SET_FRAME, 8'd64,  1'b1, 5'd31, 6'd63, 6'd63, 0},      // first clamped value
		'{OP_SET_FRAME, 8'd63,  1'b0, 5'd0,  6'd0,  6'd0,  0},
		'{OP_SET_TIME,  8'hFF,  1'b0, 5'd31, 6'd63, 6'd63, 0},      // invalid time -> 0
		'{OP_TICK,      8'd0,   1'b0, 5'd0,  6'd0,  6'd0,  0},      // still at rest
		'{OP_SET_TIME,  8'd0,   1'b1, 5'd0,  6'd0,  6'd0,  0},      // midnight -> 32
		'{OP_TICK,      8'd0,   1'b0, 5'd0,  6'd0,  6'd0,  NO_PIN},
		'{OP_TICK,      8'hFF,  1'b1, 5'd31, 6'd63, 6'd63, NO_PIN},
		'{OP_TICK,      8'd0,   1'b0, 5'd0,  6'd0,  6'd0,  NO_PIN},
		'{OP_SET_TIME,  8'd0,   1'b1, 5'd23, 6'd59, 6'd59, NO_PIN}, // last second of day
		'{OP_TICK,      8'd0,   1'b0, 5'd0,  6'd0,  6'd0,  NO_PIN},
		'{OP_SET_TIME,  8'd0,   1'b1, 5'd31, 6'd63, 6'd63, NO_PIN}, // fields past range
		'{OP_TICK,      8'd0,   1'b0, 5'd0,  6'd0,  6'd0,  NO_PIN},
		'{OP_SET_FRAME, 8'd63,  1'b0, 5'd0,  6'd0,  6'd0,  NO_PIN},
		'{OP_TICK,      8'd0,   1'b0, 5'd0,  6'd0,  6'd0,  NO_PIN},
		'{OP_SET_FRAME, 8'hAA,  1'b1, 5'd21, 6'd42, 6'd21, NO_PIN},
		'{OP_TICK,      8'h55,  1'b0, 5'd10, 6'd21, 6'd42, NO_PIN},
		'{OP_SPARE,     8'h55,  1'b0, 5'd10, 6'd21, 6'd42, NO_PIN}
	};

	// Coefficient settings; the first is the reset state and is not written.
	// The last one runs with no idling on either side.
	setting_t plan [N_SETTINGS] = '{
		'{STIFFNESS_RST, DAMPING_RST, 1'b0, 20, 20},
		'{16'hFFFF,      16'hFFFF,    1'b1, 30, 30},  // near-undamped oscillation
		'{16'h0000,      16'h0000,    1'b0, 0,  0},
		'{16'hFFFF,      16'h0000,    1'b1, 15, 40},
		'{16'h0000,      16'hFFFF,    1'b0, 40, 15},
		'{16'h0000,      16'h0000,    1'b0, 25, 25},  // drawn at run time
		'{16'h8000,      16'hE000,    1'b1, 0,  0}
	};

	// ---------------------------------------------------------------- model
	logic signed [Q_W-1:0] m_pos;
	logic signed [Q_W-1:0] m_vel;
	logic [FRAME_W-1:0]    m_target;
	logic [COEF_W-1:0]     m_stiff;
	logic [COEF_W-1:0]     m_damp;
	logic                  m_day20;

	logic [FRAME_W-1:0] frames_owed [$];  // shown frames still to come out

	int errors;
	int gap_pct;
	int stall_pct;
	int cur_pin;       // pinned result of the request on the bus
	bit squeeze_req;   // asks the receiver for one long hold-off
	int quiet_cycles;
	int results_seen;
	int ticks_seen;
	int loads_seen;
	int spare_seen;
	int top_frames;
	int input_stalls;

	function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
		if (v > Q_HI) return Q_HI[Q_W-1:0];
		if (v < Q_LO) return Q_LO[Q_W-1:0];
		return v[Q_W-1:0];
	endfunction

	// integer part of position, clamped to the frame range
	function automatic logic [FRAME_W-1:0] frame_of(input logic signed [Q_W-1:0] p);
		longint whole;
		whole = longint'(p) >>> FRAC_W;
		if (p < 0) return '0;
		if (whole > longint'(FRAME_MAX)) return FRAME_MAX;
		return whole[FRAME_W-1:0];
	endfunction

	function automatic logic [FRAME_W-1:0] frame_of_time(input logic [HOUR_W-1:0] h,
			input logic [MIN_W-1:0] m, input logic [SEC_W-1:0] s);
		int unsigned secs;
		int unsigned slot;
		secs = h * 3600 + m * 60 + s;
		slot = m_day20 ? (secs * 4) / 75 : secs / 1350;
		return FRAME_W'(slot + 32);   // half-turn offset, wraps mod 64
	endfunction

	// applies one request to the model and returns the frame it shows
	function automatic logic [FRAME_W-1:0] advance(input logic [1:0] code,
			input logic [TFRAME_W-1:0] frame, input logic tv,
			input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m,
			input logic [SEC_W-1:0] s);
		longint offset;
		longint damped;
		longint pull;
		case (code)
			OP_TICK: begin
				// floor by arithmetic shift, as the block does
				offset = longint'(m_pos) - (longint'(m_target) << FRAC_W);
				damped = (longint'(m_vel) * longint'(m_damp)) >>> FRAC_W;
				pull   = (longint'(m_stiff) * longint'(clamp_q(offset))) >>> FRAC_W;
				m_vel  = clamp_q(damped - pull);
				m_pos  = clamp_q(longint'(m_pos) + longint'(m_vel));
			end
			OP_SET_FRAME: begin
				m_target = (frame > FRAME_MAX) ? FRAME_MAX : frame[FRAME_W-1:0];
			end
			OP_SET_TIME: begin
				m_target = tv ? frame_of_time(h, m, s) : '0;
			end
			default: begin
			end
		endcase
		return frame_of(m_pos);
	endfunction

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------- monitor
	// Samples at the rising edge. Results are checked before the request of
	// the same edge is applied, so a result never meets its own expectation.
	always @(posedge clk) begin
		logic [FRAME_W-1:0] want;
		if (arst_n) begin
			quiet_cycles++;
			if (in_valid && !in_ready) input_stalls++;
			if (out_valid && out_ready) begin
				quiet_cycles = 0;
				results_seen++;
				if (display_frame == FRAME_MAX) top_frames++;
				if (frames_owed.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$error("display_frame: expected none, got %0d", display_frame);
				end else begin
					want = frames_owed.pop_front();
					if (display_frame !== want) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$error("display_frame: expected %0d, got %0d", want, display_frame);
					end
				end
			end
			if (cfg_wr_en) begin
				quiet_cycles = 0;
				case (cfg_index)
					REG_STIFFNESS: m_stiff = cfg_data;
					REG_DAMPING:   m_damp  = cfg_data;
					REG_DAY_MODE:  m_day20 = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready) begin
				quiet_cycles = 0;
				case (op) inside
					OP_TICK:                   ticks_seen++;
					OP_SET_FRAME, OP_SET_TIME: loads_seen++;
					default:                   spare_seen++;
				endcase
				want = advance(op, target_frame, time_valid, hour, minute, second);
				frames_owed.push_back((cur_pin == NO_PIN) ? want : FRAME_W'(cur_pin));
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: %0d cycles with no traffic", QUIET_LIMIT);
				$display("[spring_damped_clock_frame_tracker] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------ receiver
	// Random stall bursts, and one long hold-off on request, long enough for both
	// pipeline registers to fill and in_ready to drop.
	initial begin : result_sink
		int hold;
		hold = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				hold = SQUEEZE_CYCLES;
			end else if (hold == 0 && $urandom_range(0, 99) < stall_pct) begin
				hold = $urandom_range(1, 19);
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------- sender
	// Puts one request on the bus at a falling edge, maybe after a gap, and
	// holds it until the rising edge that takes it.
	task automatic offer(input request_t r);
		int gap;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 19);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		op           <= op_t'(r.code);
		target_frame <= r.frame;
		time_valid   <= r.tv;
		hour         <= r.h;
		minute       <= r.m;
		second       <= r.s;
		cur_pin      <= r.pinned;
		do @(posedge clk); while (!in_ready);
	endtask

	// Mostly ticks so the spring has time to move, with retargets sprinkled in.
	// Time fields are in range most of the time and full width otherwise.
	function automatic request_t random_request();
		request_t r;
		int pick;
		pick     = $urandom_range(0, 99);
		r.frame  = $urandom_range(0, 1) ? TFRAME_W'($urandom_range(0, 63))
			: TFRAME_W'($urandom_range(0, 255));
		r.tv     = ($urandom_range(0, 99) < 85);
		r.pinned = NO_PIN;
		if ($urandom_range(0, 3) == 0) begin
			r.h = HOUR_W'($urandom_range(0, 31));
			r.m = MIN_W'($urandom_range(0, 63));
			r.s = SEC_W'($urandom_range(0, 63));
		end else begin
			r.h = HOUR_W'($urandom_range(0, 23));
			r.m = MIN_W'($urandom_range(0, 59));
			r.s = SEC_W'($urandom_range(0, 59));
		end
		if (pick < 8)       r.code = OP_SET_FRAME;
		else if (pick < 14) r.code = OP_SET_TIME;
		else if (pick < 17) r.code = OP_SPARE;
		else                r.code = OP_TICK;
		return r;
	endfunction

	// drop valid, wait for every owed frame, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		cur_pin  <= NO_PIN;
		while (frames_owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	// back-to-back writes keep the enable high; it drops once after the last
	task automatic program_regs(input setting_t s);
		write_reg(REG_STIFFNESS, s.k);
		write_reg(REG_DAMPING, s.c);
		write_reg(REG_DAY_MODE, {15'($urandom_range(0, 32767)), s.mode});
		write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// ---------------------------------------------------------- main flow
	initial begin : stimulus
		setting_t s;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		op           = OP_TICK;
		target_frame = '0;
		time_valid   = 1'b0;
		hour         = '0;
		minute       = '0;
		second       = '0;
		cur_pin      = NO_PIN;
		squeeze_req  = 1'b0;
		gap_pct      = 0;
		stall_pct    = 0;
		errors       = 0;
		quiet_cycles = 0;
		results_seen = 0;
		ticks_seen   = 0;
		loads_seen   = 0;
		spare_seen   = 0;
		top_frames   = 0;
		input_stalls = 0;
		// model matches the block's reset state
		m_pos    = '0;
		m_vel    = '0;
		m_target = '0;
		m_stiff  = STIFFNESS_RST;
		m_damp   = DAMPING_RST;
		m_day20  = 1'b0;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < N_SETTINGS; p++) begin
			s = plan[p];
			if (p == RANDOM_SETTING) begin
				s.k    = COEF_W'($urandom_range(0, 65535));
				s.c    = COEF_W'($urandom_range(0, 65535));
				s.mode = 1'($urandom_range(0, 1));
			end
			if (p > 0) program_regs(s);
			gap_pct   = s.gap_pct;
			stall_pct = s.stall_pct;
			if (p == 0) begin
				foreach (script[i]) offer(script[i]);
			end
			if (p == SQUEEZE_SETTING) squeeze_req = 1'b1;
			repeat (RAND_ITEMS) offer(random_request());
			drain();
		end

		$display("%0d frames checked over %0d settings: %0d ticks, %0d retargets, %0d unused ops",
			results_seen, N_SETTINGS, ticks_seen, loads_seen, spare_seen);
		$display("%0d frames shown at the top rail, %0d cycles with a request held off",
			top_frames, input_stalls);
		if (errors == 0) begin
			$display("[spring_damped_clock_frame_tracker] OK");
		end else begin
			$display("[spring_damped_clock_frame_tracker] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/sdcft_pkg.sv
hdl/spring_damped_clock_frame_tracker.sv
tb/spring_damped_clock_frame_tracker_tb.sv
